// File: rtl/gllk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gllk_pkg
// Types, sizes and helpers shared by the genotype log-likelihood kernel.
// ----------------------------------------------------------------------------
package gllk_pkg;

    localparam int FACT_TABLE_DEPTH = 1024;
    localparam int FACT_AW          = $clog2(FACT_TABLE_DEPTH);

    localparam int IDX_W    = 10;
    localparam int VAL_W    = 32;
    localparam int CNT_W    = 10;
    localparam int TOT_W    = CNT_W + 2;
    localparam int BASES    = 4;
    localparam int GENOS    = 3;
    localparam int ERR_ROWS = 16;
    localparam int ERR_RW   = $clog2(ERR_ROWS);
    localparam int ERR_DEPTH = 192;
    localparam int LF_COPIES = BASES + 1;
    localparam int PROD_W   = CNT_W + 1 + VAL_W;
    localparam int OUT_W    = 48;
    localparam int CMP_W    = FACT_AW + TOT_W + 1;

    typedef enum logic [1:0] {
        CMD_LOAD_ERR  = 2'd0,
        CMD_LOAD_FACT = 2'd1,
        CMD_SCORE     = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [1:0]              command;
        logic [IDX_W-1:0]        table_index;
        logic signed [VAL_W-1:0] table_value;
        logic [1:0]              major_base;
        logic [1:0]              minor_base;
        logic [CNT_W-1:0]        count_a;
        logic [CNT_W-1:0]        count_c;
        logic [CNT_W-1:0]        count_g;
        logic [CNT_W-1:0]        count_t;
        logic                    site_last;
    } t_gllk_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] loglike_hom_major;
        logic signed [OUT_W-1:0] loglike_het;
        logic signed [OUT_W-1:0] loglike_hom_minor;
        logic                    depth_overflow;
        logic                    site_last_out;
    } t_gllk_out;

    // table write request from the front end
    typedef struct packed {
        logic             err_we;
        logic             lf_we;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
    } t_tbl_wr;

    function automatic logic [FACT_AW-1:0] lf_addr_idx(input logic [IDX_W-1:0] v);
        logic [FACT_AW+IDX_W-1:0] w;
        w = {{FACT_AW{1'b0}}, v};
        return w[FACT_AW-1:0];
    endfunction

    function automatic logic [FACT_AW-1:0] lf_addr_tot(input logic [TOT_W-1:0] v);
        logic [FACT_AW+TOT_W-1:0] w;
        w = {{FACT_AW{1'b0}}, v};
        return w[FACT_AW-1:0];
    endfunction

endpackage
`default_nettype wire

// File: rtl/gllk_tables.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gllk_tables
// Error and log-factorial tables. The error table is split into one bank per
// genotype and base so all twelve entries of a site come out in one read. The
// log-factorial table is held in five copies, one per read address.
// ----------------------------------------------------------------------------
module gllk_tables import gllk_pkg::*; (
    input  wire logic                          i_clk,
    input  wire t_tbl_wr                       i_wr,
    input  wire logic                          i_rd1_en,
    input  wire logic [1:0]                    i_major,
    input  wire logic [1:0]                    i_minor,
    input  wire logic [BASES-1:0][CNT_W-1:0]   i_cnt,
    input  wire logic                          i_rd2_en,
    input  wire logic [TOT_W-1:0]              i_total,
    output logic [GENOS-1:0][BASES-1:0][VAL_W-1:0] o_err,
    output logic [BASES-1:0][VAL_W-1:0]        o_lf_cnt,
    output logic [VAL_W-1:0]                   o_lf_total
);

    logic [VAL_W-1:0] r_err_mem [GENOS][BASES][ERR_ROWS];
    logic [VAL_W-1:0] r_lf_mem  [LF_COPIES][FACT_TABLE_DEPTH];
    logic [GENOS-1:0][BASES-1:0][VAL_W-1:0] r_err_rd;
    logic [LF_COPIES-1:0][VAL_W-1:0]        r_lf_rd;
    logic [ERR_RW-1:0]  rd_row;
    logic [ERR_RW-1:0]  wr_row;
    logic [FACT_AW-1:0] lf_wr_addr;

    assign rd_row     = {i_major, i_minor};
    // index = geno*64 + major*16 + minor*4 + base
    assign wr_row     = i_wr.index[5:2];
    assign lf_wr_addr = lf_addr_idx(i_wr.index);

    for (genvar g = 0; g < GENOS; g++) begin : g_geno
        for (genvar b = 0; b < BASES; b++) begin : g_base
            always_ff @(posedge i_clk) begin
                if (i_wr.err_we && i_wr.index[7:6] == 2'(g) && i_wr.index[1:0] == 2'(b)) begin
                    r_err_mem[g][b][wr_row] <= i_wr.value;
                end
                if (i_rd1_en) begin
                    r_err_rd[g][b] <= r_err_mem[g][b][rd_row];
                end
            end
        end
    end

    for (genvar c = 0; c < LF_COPIES; c++) begin : g_lf
        always_ff @(posedge i_clk) begin
            if (i_wr.lf_we) begin
                r_lf_mem[c][lf_wr_addr] <= i_wr.value;
            end
            if (c < BASES) begin
                if (i_rd1_en) begin
                    r_lf_rd[c] <= r_lf_mem[c][lf_addr_idx(i_cnt[c % BASES])];
                end
            end else begin
                // total is read from the stage 1 register, once it has been summed
                if (i_rd2_en) begin
                    r_lf_rd[c] <= r_lf_mem[c][lf_addr_tot(i_total)];
                end
            end
        end
    end

    assign o_err      = r_err_rd;
    assign o_lf_cnt   = r_lf_rd[BASES-1:0];
    assign o_lf_total = r_lf_rd[BASES];

endmodule
`default_nettype wire

// File: rtl/genotype_log_likelihood_kernel_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// genotype_log_likelihood_kernel_unit
// Multinomial log-likelihood of three genotypes from four read counts.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the output is not stalled; the count
// table reads, the twelve multipliers with the total read, and each level of
// the two-level adder tree occupy one stage each.
// Load items write the tables at acceptance and give no result.
// Reset clears the stage valid bits only; table contents are undefined
// until loaded.
module genotype_log_likelihood_kernel_unit import gllk_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_gllk_in  i_in_item,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output t_gllk_out      o_out_item,
    input  wire logic      i_out_stall
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic accept, is_score;

    // stage 1
    logic [BASES-1:0][CNT_W-1:0] r_s1_cnt;
    logic [TOT_W-1:0]            r_s1_total;
    logic                        r_s1_ovf, r_s1_last;
    // stage 2
    logic signed [PROD_W-1:0]    r_s2_prod [GENOS][BASES];
    logic signed [OUT_W-1:0]     r_s2_lf_sum;
    logic                        r_s2_ovf, r_s2_last;
    // stage 3
    logic signed [OUT_W-1:0]     r_s3_pa [GENOS];
    logic signed [OUT_W-1:0]     r_s3_pb [GENOS];
    logic signed [OUT_W-1:0]     r_s3_base;
    logic                        r_s3_ovf, r_s3_last;
    // stage 4
    t_gllk_out                   r_out;

    logic [BASES-1:0][CNT_W-1:0] in_cnt;
    logic [TOT_W-1:0]            in_total;
    logic [1:0]                  minor_fix;
    logic                        in_ovf;
    logic [IDX_W+8-1:0]          idx_wide;
    t_tbl_wr                     tbl_wr;
    logic [GENOS-1:0][BASES-1:0][VAL_W-1:0] err_rd;
    logic [BASES-1:0][VAL_W-1:0] lf_cnt_rd;
    logic [VAL_W-1:0]            lf_total_rd;
    logic signed [OUT_W-1:0]     n_lf_sum;
    logic signed [OUT_W-1:0]     n_ll [GENOS];

    // ready ripples back; a stage with a bubble takes a new item even when
    // the output is held
    assign rdy4 = !r_v4 || !i_out_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_in_stall = !rdy1;
    assign accept     = i_in_valid && rdy1;
    assign is_score   = i_in_item.command == CMD_SCORE;

    assign in_cnt   = {i_in_item.count_t, i_in_item.count_g,
                       i_in_item.count_c, i_in_item.count_a};
    assign in_total = TOT_W'(i_in_item.count_a) + TOT_W'(i_in_item.count_c)
                    + TOT_W'(i_in_item.count_g) + TOT_W'(i_in_item.count_t);
    assign in_ovf   = {{(CMP_W-TOT_W){1'b0}}, in_total} >= CMP_W'(FACT_TABLE_DEPTH);

    // equal major and minor: minor falls back to A, or C when major is A
    always_comb begin
        minor_fix = i_in_item.minor_base;
        if (i_in_item.major_base == i_in_item.minor_base) begin
            minor_fix = (i_in_item.major_base != 2'd0) ? 2'd0 : 2'd1;
        end
    end

    assign idx_wide      = {8'd0, i_in_item.table_index};
    assign tbl_wr.err_we = accept && i_in_item.command == CMD_LOAD_ERR
                        && idx_wide < (IDX_W+8)'(ERR_DEPTH);
    assign tbl_wr.lf_we  = accept && i_in_item.command == CMD_LOAD_FACT
                        && {{FACT_AW{1'b0}}, i_in_item.table_index}
                           < (FACT_AW+IDX_W)'(FACT_TABLE_DEPTH);
    assign tbl_wr.index  = i_in_item.table_index;
    assign tbl_wr.value  = i_in_item.table_value;

    gllk_tables u_tables (
        .i_clk      (i_clk),
        .i_wr       (tbl_wr),
        .i_rd1_en   (rdy1),
        .i_major    (i_in_item.major_base),
        .i_minor    (minor_fix),
        .i_cnt      (in_cnt),
        .i_rd2_en   (rdy2),
        .i_total    (r_s1_total),
        .o_err      (err_rd),
        .o_lf_cnt   (lf_cnt_rd),
        .o_lf_total (lf_total_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= accept && is_score;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    assign n_lf_sum = OUT_W'($signed(lf_cnt_rd[0])) + OUT_W'($signed(lf_cnt_rd[1]))
                    + OUT_W'($signed(lf_cnt_rd[2])) + OUT_W'($signed(lf_cnt_rd[3]));

    always_comb begin
        for (int g = 0; g < GENOS; g++) begin
            n_ll[g] = r_s3_ovf ? '0 : (r_s3_pa[g] + r_s3_pb[g] + r_s3_base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_cnt   <= in_cnt;
            r_s1_total <= in_total;
            r_s1_ovf   <= in_ovf;
            r_s1_last  <= i_in_item.site_last;
        end
        if (rdy2) begin
            for (int g = 0; g < GENOS; g++) begin
                for (int b = 0; b < BASES; b++) begin
                    r_s2_prod[g][b] <= PROD_W'($signed({1'b0, r_s1_cnt[b]})
                                               * $signed(err_rd[g][b]));
                end
            end
            r_s2_lf_sum <= n_lf_sum;
            r_s2_ovf    <= r_s1_ovf;
            r_s2_last   <= r_s1_last;
        end
        if (rdy3) begin
            for (int g = 0; g < GENOS; g++) begin
                r_s3_pa[g] <= OUT_W'(r_s2_prod[g][0]) + OUT_W'(r_s2_prod[g][1]);
                r_s3_pb[g] <= OUT_W'(r_s2_prod[g][2]) + OUT_W'(r_s2_prod[g][3]);
            end
            r_s3_base <= OUT_W'($signed(lf_total_rd)) - r_s2_lf_sum;
            r_s3_ovf  <= r_s2_ovf;
            r_s3_last <= r_s2_last;
        end
        if (rdy4) begin
            r_out.loglike_hom_major <= n_ll[0];
            r_out.loglike_het       <= n_ll[1];
            r_out.loglike_hom_minor <= n_ll[2];
            r_out.depth_overflow    <= r_s3_ovf;
            r_out.site_last_out     <= r_s3_last;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_item  = r_out;

    // an overflowed depth never carries a likelihood
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.depth_overflow |->
            o_out_item.loglike_hom_major == '0 && o_out_item.loglike_het == '0
            && o_out_item.loglike_hom_minor == '0)
        else $error("overflow result with non-zero likelihood");

    // load items never enter the scoring pipeline
    a_load_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !is_score |=> !r_v1)
        else $error("load item produced a pipeline item");

    // a bubble in the first stage always lets the input in
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> !o_in_stall)
        else $error("input stalled with empty first stage");

    // an item waiting at the output keeps its place until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_v4 && i_out_stall |=> r_v3 && r_v4)
        else $error("pipeline item lost under output stall");

endmodule
`default_nettype wire
